FILE: sv/median_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Median priority queue assertion macros
// Shared helpers for the concurrent checks; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_PRIORITY_QUEUE_DEFINES_SVH
`define MEDIAN_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define MPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpq: same-cycle check failed");

// next-cycle implication
`define MPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpq: next-cycle check failed");

`endif

FILE: sv/mpq_pkg.sv
// ----------------------------------------------------------------------------
// Median priority queue package
// Sizes, codes and beat types shared by the queue, its cell row and checker.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int CAPACITY = 256;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int MID_POS  = (CAPACITY - 1) / 2;
	localparam int KEY_W    = 32;
	localparam int TAG_W    = 32;
	localparam int COUNT_W  = 9;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DEL_MIN = 2'd1,
		OP_DEL_MAX = 2'd2,
		OP_PEEK    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast along a row
	typedef enum logic [2:0] {
		CM_HOLD  = 3'd0,
		CM_SHL   = 3'd1,
		CM_SHR   = 3'd2,
		CM_INS_R = 3'd3,
		CM_INS_L = 3'd4
	} cell_mode_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} entry_t;

	// lo/end_pos bound the occupied span [lo, end_pos) of a row
	typedef struct packed {
		cell_mode_t mode;
		entry_t     ins;
		cnt_t       lo;
		cnt_t       end_pos;
	} row_ctl_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [KEY_W-1:0] key_in;
		logic [TAG_W-1:0]        tag_in;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic signed [KEY_W-1:0] removed_key;
		logic [TAG_W-1:0]        removed_tag;
		logic [COUNT_W-1:0]      entry_count;
		logic signed [KEY_W-1:0] min_key;
		logic [TAG_W-1:0]        min_tag;
		logic signed [KEY_W-1:0] max_key;
		logic [TAG_W-1:0]        max_tag;
		logic signed [KEY_W-1:0] median_key;
		logic [TAG_W-1:0]        median_tag;
	} rsp_t;

endpackage

FILE: sv/mpq_cell.sv
// ----------------------------------------------------------------------------
// Median priority queue cell
// One sorted slot: holds, shifts from a neighbor, or takes the new entry.
// ----------------------------------------------------------------------------
module mpq_cell import mpq_pkg::*; (
	input  logic     clk,
	input  row_ctl_t ctl,
	input  cnt_t     idx,
	input  entry_t   left_ent,
	input  logic     left_gt,
	input  entry_t   right_ent,
	input  logic     right_gt,
	output entry_t   ent_q,
	output logic     gt
);

	logic   above_end;
	logic   below_lo;
	logic   key_gt;
	entry_t ent_d;

	// empty slots right of the span count as larger, left of it as smaller
	assign above_end = (idx >= ctl.end_pos);
	assign below_lo  = (idx < ctl.lo);
	assign key_gt    = ($signed(ent_q.key) > $signed(ctl.ins.key));
	assign gt        = above_end | (~below_lo & key_gt);

	always_comb begin
		ent_d = ent_q;
		case (ctl.mode)
			CM_HOLD:  ent_d = ent_q;
			CM_SHL:   ent_d = right_ent;
			CM_SHR:   ent_d = left_ent;
			CM_INS_R: begin
				if (gt) begin
					ent_d = left_gt ? left_ent : ctl.ins;
				end
			end
			CM_INS_L: begin
				if (!gt) begin
					ent_d = right_gt ? ctl.ins : right_ent;
				end
			end
			default:  ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

FILE: sv/mpq_row.sv
// ----------------------------------------------------------------------------
// Median priority queue cell row
// CAPACITY cells in a line, each wired to its neighbors; the end cells see fixed edge values.
// ----------------------------------------------------------------------------
module mpq_row import mpq_pkg::*; (
	input  logic     clk,
	input  row_ctl_t ctl,
	output entry_t   cells [CAPACITY]
);

	logic [CAPACITY-1:0] gt;

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		logic   left_gt;
		logic   right_gt;

		if (gi == 0) begin : g_first
			assign left_ent = '0;
			assign left_gt  = 1'b0;
		end else begin : g_inner_l
			assign left_ent = cells[gi-1];
			assign left_gt  = gt[gi-1];
		end

		if (gi == CAPACITY - 1) begin : g_last
			assign right_ent = '0;
			assign right_gt  = 1'b1;
		end else begin : g_inner_r
			assign right_ent = cells[gi+1];
			assign right_gt  = gt[gi+1];
		end

		mpq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (cnt_t'(gi)),
			.left_ent  (left_ent),
			.left_gt   (left_gt),
			.right_ent (right_ent),
			.right_gt  (right_gt),
			.ent_q     (cells[gi]),
			.gt        (gt[gi])
		);
	end

endmodule

FILE: sv/median_priority_queue.sv
// Flow: a request beat accepted in S_IDLE or S_RESP is held in req_q, applied to the
//   cell rows in S_EXEC, and its response is loaded in S_RESP once rsp_stall allows;
//   the next request waits for the edge that loads the response register.
// Reset: arst_n clears the entry count, the sequencer and response valid; the cell
//   rows hold garbage until written and are never read outside the occupied span.
// ----------------------------------------------------------------------------
// Median priority queue
// Bounded sorted multiset of (key, tag) entries with min, max and lower median
// taps, built from three rows of systolic cells updated in lockstep.
// ----------------------------------------------------------------------------
module median_priority_queue import mpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// Three copies of the sorted contents, all updated in the same cycle:
	//   row A is anchored left, so cell 0 is the minimum;
	//   row B is anchored right, so cell CAPACITY-1 is the maximum;
	//   row C is anchored on the lower median, which always sits in cell MID_POS.
	// Each row gets a broadcast command plus the bounds of its occupied span;
	// cells outside the span compare as larger (right side) or smaller (left side).

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t   state_q, state_d;
	req_t     req_q;
	cnt_t     count_q, count_d;
	status_t  status_q, status_d;
	entry_t   removed_q, removed_d;
	rsp_t     rsp_q;
	logic     rsp_valid_q;

	logic     req_accept;
	logic     load_rsp;
	logic     in_exec;
	logic     do_op;
	logic     n_odd;
	logic     cnt_full;
	logic     cnt_empty;
	logic [CNT_W:0] half_up;
	cnt_t     c_lo;

	row_ctl_t ctl_a, ctl_b, ctl_c;
	entry_t   row_a [CAPACITY];
	entry_t   row_b [CAPACITY];
	entry_t   row_c [CAPACITY];

	// ------------------------------------------------------------------
	// Handshake and sequencer
	// ------------------------------------------------------------------
	assign load_rsp   = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);
	assign req_stall  = !((state_q == S_IDLE) || load_rsp);
	assign req_accept = req_valid && !req_stall;
	assign in_exec    = (state_q == S_EXEC);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_RESP;
			S_RESP: begin
				if (load_rsp) begin
					state_d = req_accept ? S_EXEC : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request beat is held for the update cycle
	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_q <= req;
		end
	end

	// ------------------------------------------------------------------
	// Update cycle: status, count and row commands
	// ------------------------------------------------------------------
	assign cnt_full  = (count_q == cnt_t'(CAPACITY));
	assign cnt_empty = (count_q == '0);
	assign n_odd     = count_q[0];

	always_comb begin
		status_d = ST_OK;
		case (req_q.operation)
			OP_INSERT: status_d = cnt_full ? ST_FULL : ST_OK;
			default:   status_d = cnt_empty ? ST_EMPTY : ST_OK;
		endcase
	end

	assign do_op = in_exec && (status_d == ST_OK);

	// lower end of row C: the median stays in MID_POS, so the span starts
	// ceil(n/2) - 1 cells before it (one past it when empty)
	assign half_up = ((CNT_W+1)'(count_q) + (CNT_W+1)'(1)) >> 1;
	assign c_lo    = cnt_t'(MID_POS + 1) - cnt_t'(half_up);

	always_comb begin
		ctl_a         = '0;
		ctl_a.mode    = CM_HOLD;
		ctl_a.ins     = '{key: req_q.key_in, tag: req_q.tag_in};
		ctl_a.lo      = '0;
		ctl_a.end_pos = count_q;

		ctl_b         = ctl_a;
		ctl_b.lo      = cnt_t'(CAPACITY) - count_q;
		ctl_b.end_pos = cnt_t'(CAPACITY);

		ctl_c         = ctl_a;
		ctl_c.lo      = c_lo;
		ctl_c.end_pos = c_lo + count_q;

		count_d       = count_q;

		if (do_op) begin
			case (req_q.operation)
				OP_INSERT: begin
					ctl_a.mode = CM_INS_R;
					ctl_b.mode = CM_INS_L;
					// odd count keeps the median index, even count moves it up
					ctl_c.mode = n_odd ? CM_INS_R : CM_INS_L;
					count_d    = count_q + cnt_t'(1);
				end
				OP_DEL_MIN: begin
					ctl_a.mode = CM_SHL;
					ctl_c.mode = n_odd ? CM_HOLD : CM_SHL;
					count_d    = count_q - cnt_t'(1);
				end
				OP_DEL_MAX: begin
					ctl_b.mode = CM_SHR;
					ctl_c.mode = n_odd ? CM_SHR : CM_HOLD;
					count_d    = count_q - cnt_t'(1);
				end
				default: begin
					ctl_a.mode = CM_HOLD;
				end
			endcase
		end
	end

	always_comb begin
		removed_d = '0;
		if (do_op) begin
			case (req_q.operation)
				OP_DEL_MIN: removed_d = row_a[0];
				OP_DEL_MAX: removed_d = row_b[CAPACITY-1];
				default:    removed_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_exec) begin
			status_q  <= status_d;
			removed_q <= removed_d;
		end
	end

	// ------------------------------------------------------------------
	// Cell rows
	// ------------------------------------------------------------------
	mpq_row u_row_min (
		.clk   (clk),
		.ctl   (ctl_a),
		.cells (row_a)
	);

	mpq_row u_row_max (
		.clk   (clk),
		.ctl   (ctl_b),
		.cells (row_b)
	);

	mpq_row u_row_med (
		.clk   (clk),
		.ctl   (ctl_c),
		.cells (row_c)
	);

	// ------------------------------------------------------------------
	// Response register: taps read after the rows settled
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.status      <= status_q;
			rsp_q.removed_key <= removed_q.key;
			rsp_q.removed_tag <= removed_q.tag;
			rsp_q.entry_count <= COUNT_W'(count_q);
			if (count_q != '0) begin
				rsp_q.min_key    <= row_a[0].key;
				rsp_q.min_tag    <= row_a[0].tag;
				rsp_q.max_key    <= row_b[CAPACITY-1].key;
				rsp_q.max_tag    <= row_b[CAPACITY-1].tag;
				rsp_q.median_key <= row_c[MID_POS].key;
				rsp_q.median_tag <= row_c[MID_POS].tag;
			end else begin
				rsp_q.min_key    <= '0;
				rsp_q.min_tag    <= '0;
				rsp_q.max_key    <= '0;
				rsp_q.max_tag    <= '0;
				rsp_q.median_key <= '0;
				rsp_q.median_tag <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sv/mpq_checker.sv
// ----------------------------------------------------------------------------
// Median priority queue checker
// Port-level checks on the queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "median_priority_queue_defines.svh"

module mpq_port_checks import mpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic rsp_beat;

	assign rsp_beat = rsp_valid && !rsp_stall;

	// a taken request keeps the input side busy for the update cycle
	`MPQ_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

	// stalled response beat holds
	`MPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// nothing held: all taps read as zero
	`MPQ_ASSERT_NOW(a_empty_taps, rsp_beat && rsp.entry_count == '0, rsp.min_key == '0 && rsp.min_tag == '0 && rsp.max_key == '0 && rsp.max_tag == '0 && rsp.median_key == '0 && rsp.median_tag == '0)

	// taps from the three rows agree on order
	`MPQ_ASSERT_NOW(a_tap_order, rsp_beat && rsp.entry_count != '0, rsp.min_key <= rsp.median_key && rsp.median_key <= rsp.max_key)

	// failed request removes nothing
	`MPQ_ASSERT_NOW(a_fail_no_removal, rsp_beat && rsp.status != ST_OK, rsp.removed_key == '0 && rsp.removed_tag == '0)

endmodule

bind median_priority_queue mpq_port_checks u_mpq_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

FILE: verif/mpq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median priority queue checker
// Watches both channels, keeps a sorted shadow of the held entries, predicts
// each response beat and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module mpq_checker import mpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   mismatches,
	output int   awaiting
);

	entry_t shadow_set[$];    // ascending; ties keep arrival order
	rsp_t   pending_rsp[$];
	int     fail_tally;

	task automatic report_mismatch(input string what);
		fail_tally++;
		if (fail_tally <= 100) begin
			$display("mpq_checker: %0t: %s", $time, what);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
		end
	endtask

	function automatic rsp_t apply_request(input req_t r);
		rsp_t   o;
		entry_t e;
		int     pos;
		int     n;
		o = '0;
		o.status = ST_OK;
		if (r.operation == OP_INSERT) begin
			if (shadow_set.size() >= CAPACITY) begin
				o.status = ST_FULL;
			end else begin
				// new entry lands after every entry that is not greater
				pos = 0;
				while (pos < shadow_set.size() &&
						$signed(shadow_set[pos].key) <= $signed(r.key_in)) begin
					pos++;
				end
				e.key = r.key_in;
				e.tag = r.tag_in;
				shadow_set.insert(pos, e);
			end
		end else if (shadow_set.size() == 0) begin
			o.status = ST_EMPTY;
		end else if (r.operation == OP_DEL_MIN) begin
			e = shadow_set.pop_front();
			o.removed_key = e.key;
			o.removed_tag = e.tag;
		end else if (r.operation == OP_DEL_MAX) begin
			e = shadow_set.pop_back();
			o.removed_key = e.key;
			o.removed_tag = e.tag;
		end
		n = shadow_set.size();
		o.entry_count = n[COUNT_W-1:0];
		if (n > 0) begin
			o.min_key    = shadow_set[0].key;
			o.min_tag    = shadow_set[0].tag;
			o.max_key    = shadow_set[n-1].key;
			o.max_tag    = shadow_set[n-1].tag;
			o.median_key = shadow_set[(n-1)/2].key;
			o.median_tag = shadow_set[(n-1)/2].tag;
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			shadow_set.delete();
			pending_rsp.delete();
			awaiting   <= 0;
			mismatches <= fail_tally;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("response beat with no request outstanding");
				end else begin
					want = pending_rsp.pop_front();
					check_field("status", rsp.status, want.status);
					check_field("removed_key", rsp.removed_key, want.removed_key);
					check_field("removed_tag", rsp.removed_tag, want.removed_tag);
					check_field("entry_count", rsp.entry_count, want.entry_count);
					check_field("min_key", rsp.min_key, want.min_key);
					check_field("min_tag", rsp.min_tag, want.min_tag);
					check_field("max_key", rsp.max_key, want.max_key);
					check_field("max_tag", rsp.max_tag, want.max_tag);
					check_field("median_key", rsp.median_key, want.median_key);
					check_field("median_tag", rsp.median_tag, want.median_tag);
				end
			end
			if (req_valid && !req_stall) begin
				pending_rsp.push_back(apply_request(req));
			end
			awaiting   <= pending_rsp.size();
			mismatches <= fail_tally;
		end
	end

endmodule

FILE: verif/tb_median_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median priority queue testbench
// Drives request beats through directed corner cases and then phases of
// random traffic that fill the store to full and drain it to empty, with
// bursty idling on both channels; the checker beside the block scores it.
// ----------------------------------------------------------------------------
module tb_median_priority_queue;
	import mpq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int   mismatches;
	int   awaiting;
	int   cycles;
	int   held_est;   // entry count as the stimulus side sees it
	bit   calm;       // no idling on either side once set

	median_priority_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	mpq_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: generous bound over the slowest legal run
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_median_priority_queue: errors");
		$finish;
	end

	// response side: random stall and no-stall bursts; each burst sets the
	// line once, so it never sees two updates in one step
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// keys lean on the extremes and on a narrow band so ties are common
	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 32'h7fff_ffff;
		if (sel == 1) return 32'h8000_0000;
		if (sel == 2) return 32'h0000_0000;
		if (sel == 3) return 32'hffff_ffff;
		if (sel < 7) return $urandom_range(0, 16) - 8;
		return $urandom;
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		int sel;
		sel = $urandom_range(0, 15);
		if (sel == 0) return '0;
		if (sel == 1) return '1;
		return $urandom;
	endfunction

	// insert with the given percentage, else an even pick of the other three
	function automatic op_t pick_op(input int ins_pct);
		if ($urandom_range(0, 99) < ins_pct) return OP_INSERT;
		return op_t'($urandom_range(1, 3));
	endfunction

	// one request beat; optional idle burst first, then hold until taken
	task automatic push_request(input op_t op, input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag);
		req_t r;
		r.operation = op;
		r.key_in    = key;
		r.tag_in    = tag;
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		if (op == OP_INSERT) begin
			if (held_est < CAPACITY) held_est++;
		end else if (op != OP_PEEK) begin
			if (held_est > 0) held_est--;
		end
	endtask

	task automatic random_beat(input int ins_pct);
		push_request(pick_op(ins_pct), pick_key(), pick_tag());
	endtask

	initial begin
		int full_hits;
		int empty_hits;
		int guard;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		held_est  = 0;
		calm      = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: every non-insert fails
		push_request(OP_PEEK, 32'h0, 32'h0);
		push_request(OP_DEL_MIN, 32'hffff_ffff, 32'hffff_ffff);
		push_request(OP_DEL_MAX, 32'h0, 32'h0);
		// single entry removed by delete-max, then by delete-min
		push_request(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
		push_request(OP_DEL_MAX, 32'h0, 32'h0);
		push_request(OP_INSERT, 32'h8000_0000, 32'h0000_0000);
		push_request(OP_DEL_MIN, 32'h0, 32'h0);
		// equal keys: arrival order breaks the tie
		push_request(OP_INSERT, 32'd5, 32'haaaa_0001);
		push_request(OP_INSERT, 32'd5, 32'haaaa_0002);
		push_request(OP_INSERT, 32'd5, 32'haaaa_0003);
		push_request(OP_PEEK, 32'h0, 32'h0);
		push_request(OP_DEL_MIN, 32'h0, 32'h0);
		push_request(OP_DEL_MAX, 32'h0, 32'h0);
		push_request(OP_DEL_MIN, 32'h0, 32'h0);
		// signed ordering across the extremes
		push_request(OP_INSERT, 32'h7fff_ffff, 32'h1111_1111);
		push_request(OP_INSERT, 32'h8000_0000, 32'h2222_2222);
		push_request(OP_INSERT, 32'hffff_ffff, 32'h3333_3333);
		push_request(OP_INSERT, 32'h0000_0000, 32'h4444_4444);
		push_request(OP_INSERT, 32'h0000_0001, 32'h5555_5555);
		push_request(OP_PEEK, 32'h0, 32'h0);
		push_request(OP_DEL_MAX, 32'h0, 32'h0);
		push_request(OP_DEL_MIN, 32'h0, 32'h0);
		push_request(OP_DEL_MIN, 32'h0, 32'h0);
		push_request(OP_DEL_MIN, 32'h0, 32'h0);
		push_request(OP_DEL_MAX, 32'h0, 32'h0);

		// mixed traffic around small counts
		repeat (150) random_beat(40);

		// fill to capacity and keep pushing into the full store
		full_hits = 0;
		guard     = 0;
		while (full_hits < 12 && guard < 900) begin
			if (held_est == CAPACITY) begin
				if ($urandom_range(0, 2) != 0) full_hits++;
				random_beat(70);
			end else begin
				random_beat(85);
			end
			guard++;
		end

		// churn near the top
		repeat (200) random_beat(50);

		// drain to empty and poke the empty store
		empty_hits = 0;
		guard      = 0;
		while (empty_hits < 10 && guard < 900) begin
			if (held_est == 0) empty_hits++;
			random_beat(10);
			guard++;
		end

		repeat (150) random_beat(45);

		// closing stretch with no idling on either channel
		calm = 1'b1;
		repeat (250) random_beat(55);

		req_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_median_priority_queue: clean");
		end else begin
			$display("tb_median_priority_queue: errors");
		end
		$finish;
	end

endmodule

FILE: median_priority_queue.f
+incdir+sv
sv/mpq_pkg.sv
sv/mpq_cell.sv
sv/mpq_row.sv
sv/median_priority_queue.sv
sv/mpq_checker.sv
verif/mpq_checker.sv
verif/tb_median_priority_queue.sv
